FILE: rtl/core/vat_pkg.sv
package vat_pkg;

    // Field and datapath widths
    localparam int CoordW   = 32;
    localparam int RegW     = 64;
    localparam int NumRegs  = 6;
    localparam int IdxW     = 3;
    localparam int NumCols  = 3;
    localparam int NumMul   = 3;
    localparam int ProdW    = 2 * CoordW;
    localparam int FracW    = 16;
    // floor(product / 2^16) needs ProdW - FracW bits; two levels of adds add two
    localparam int SumW     = ProdW - FracW + 2;
    localparam int TdataW   = 3 * CoordW;

    // Register indexes
    localparam logic [IdxW-1:0] RegXcol01 = 3'd0;
    localparam logic [IdxW-1:0] RegXcol23 = 3'd1;
    localparam logic [IdxW-1:0] RegYcol01 = 3'd2;
    localparam logic [IdxW-1:0] RegYcol23 = 3'd3;
    localparam logic [IdxW-1:0] RegZcol01 = 3'd4;
    localparam logic [IdxW-1:0] RegZcol23 = 3'd5;

    // Matrix defaults after reset
    localparam logic [RegW-1:0] RstXcol01 = 64'h0000_0001_0000_0000;
    localparam logic [RegW-1:0] RstXcol23 = 64'h0000_0000_0000_0000;
    localparam logic [RegW-1:0] RstYcol01 = 64'h0001_0000_0000_0000;
    localparam logic [RegW-1:0] RstYcol23 = 64'h0000_0000_0000_0000;
    localparam logic [RegW-1:0] RstZcol01 = 64'h0000_0000_0000_0000;
    localparam logic [RegW-1:0] RstZcol23 = 64'h0000_0000_0001_0000;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [SumW-1:0]   t_sum;

    // Clamp a wide sum to the signed 32-bit range
    function automatic t_coord sat_coord(input t_sum s);
        logic [SumW-CoordW:0] top;
        top = s[SumW-1:CoordW-1];
        if (&top || ~|top) begin
            return s[CoordW-1:0];
        end else if (s[SumW-1]) begin
            return {1'b1, {(CoordW-1){1'b0}}};
        end else begin
            return {1'b0, {(CoordW-1){1'b1}}};
        end
    endfunction

endpackage

FILE: rtl/core/vertex_affine_transform.sv
// Pipeline: 3 register stages (multiply, pair add, final add+clamp); the result is held in
// the output register of the last stage until it is taken.
// Throughput: 1 item per cycle; only output stalls slow it.
// Each stage loads whenever it is empty or its successor loads, so bubbles close up
// and input is still taken while a result waits at the output register.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the default matrix.
module vertex_affine_transform
    import vat_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic [IdxW-1:0]   i_cfg_idx,
    input  logic [RegW-1:0]   i_cfg_data,
    // input vertex
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [TdataW-1:0] s_axis_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic              s_axis_tlast,   // batch_end
    // transformed vertex
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [TdataW-1:0] m_axis_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic              m_axis_tlast    // out_last
);

    // Matrix registers
    logic [RegW-1:0] r_cfg [NumRegs];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[RegXcol01] <= RstXcol01;
            r_cfg[RegXcol23] <= RstXcol23;
            r_cfg[RegYcol01] <= RstYcol01;
            r_cfg[RegYcol23] <= RstYcol23;
            r_cfg[RegZcol01] <= RstZcol01;
            r_cfg[RegZcol23] <= RstZcol23;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegXcol01: r_cfg[RegXcol01] <= i_cfg_data;
                RegXcol23: r_cfg[RegXcol23] <= i_cfg_data;
                RegYcol01: r_cfg[RegYcol01] <= i_cfg_data;
                RegYcol23: r_cfg[RegYcol23] <= i_cfg_data;
                RegZcol01: r_cfg[RegZcol01] <= i_cfg_data;
                RegZcol23: r_cfg[RegZcol23] <= i_cfg_data;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // Per-column matrix entries: rows 0..2 multiply x,y,z; row 3 is the translation
    t_coord m_lin [NumCols][NumMul];
    t_coord m_trn [NumCols];

    always_comb begin
        for (int j = 0; j < NumCols; j++) begin
            m_lin[j][0] = r_cfg[2*j][CoordW-1:0];
            m_lin[j][1] = r_cfg[2*j][RegW-1:CoordW];
            m_lin[j][2] = r_cfg[2*j+1][CoordW-1:0];
            m_trn[j]    = r_cfg[2*j+1][RegW-1:CoordW];
        end
    end

    // Stage handshake: a stage loads when empty or when its successor loads
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3          = !r_v3 || m_axis_tready;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Input coordinates
    t_coord pos [NumMul];

    always_comb begin
        for (int i = 0; i < NumMul; i++) begin
            pos[i] = s_axis_tdata[i*CoordW +: CoordW];
        end
    end

    // Stage 1: nine full products
    t_prod r_prod [NumCols][NumMul];
    logic  r_last1;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            for (int j = 0; j < NumCols; j++) begin
                for (int i = 0; i < NumMul; i++) begin
                    r_prod[j][i] <= pos[i] * m_lin[j][i];
                end
            end
            r_last1 <= s_axis_tlast;
        end
    end

    // Floor shift by the fraction width, sign-extended to the sum width
    function automatic t_sum shr_frac(input t_prod p);
        return {{(SumW-(ProdW-FracW)){p[ProdW-1]}}, p[ProdW-1:FracW]};
    endfunction

    // Stage 2: two partial sums per column; translation enters unshifted
    t_sum r_sa [NumCols];
    t_sum r_sb [NumCols];
    logic r_last2;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int j = 0; j < NumCols; j++) begin
                r_sa[j] <= shr_frac(r_prod[j][0]) + shr_frac(r_prod[j][1]);
                r_sb[j] <= shr_frac(r_prod[j][2])
                         + {{(SumW-CoordW){m_trn[j][CoordW-1]}}, m_trn[j]};
            end
            r_last2 <= r_last1;
        end
    end

    // Stage 3: final add and clamp into the output register
    t_coord r_out [NumCols];
    logic   r_last3;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            for (int j = 0; j < NumCols; j++) begin
                r_out[j] <= sat_coord(r_sa[j] + r_sb[j]);
            end
            r_last3 <= r_last2;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tlast  = r_last3;

endmodule
